// File: rtl/core/fai_pkg.sv
// fai_pkg: widths, codes, stage records and the divider step for the
// frame averaging block with invalid-pixel mask
// depends on nothing; imported by frame_average_invalid_mask_top
package fai_pkg;

  // image geometry
  localparam int IMAGE_SIZE = 512;
  localparam int ROW_W      = $clog2(IMAGE_SIZE);
  localparam int ADDR_W     = 2 * ROW_W;
  localparam int DEPTH      = IMAGE_SIZE * IMAGE_SIZE;
  localparam int COORD_W    = 9;

  // group length
  localparam int MAX_FRAMES = 255;
  localparam int FRAME_W    = $clog2(MAX_FRAMES + 1);
  localparam int FRAMEP_W   = FRAME_W + 1;

  // per-pixel store: sum and invalid count
  localparam int SUM_W = 40;
  localparam int CNT_W = 8;
  localparam int MEM_W = SUM_W + CNT_W;
  localparam int FK_W  = (FRAME_W > CNT_W) ? FRAME_W : CNT_W;

  // configuration registers
  localparam int FRAMES_REG_W = 8;
  localparam int WSTART_W     = 9;
  localparam int WEND_W       = 10;
  localparam int CMP_W        = (ROW_W > WEND_W) ? ROW_W : WEND_W;
  localparam int PADDR_W      = 4;
  localparam int PDATA_W      = 32;
  localparam int REG_IDX_W    = 2;

  localparam logic [REG_IDX_W-1:0] REG_FRAMES    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_WIN_START = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WIN_END   = 2'd2;

  // pixel data
  localparam int PIX_W = 32;
  localparam logic [PIX_W-1:0] FILL_Q16 = 32'hD8F1_0000;  // -9999.0 in Q16.16
  localparam logic [PIX_W-1:0] PIX_MAX  = 32'h7FFF_FFFF;
  localparam logic [PIX_W-1:0] PIX_MIN  = 32'h8000_0000;

  // divider: rounded quotient of (2*|sum| + div) / (2*div)
  localparam int DIV_W      = FRAME_W;
  localparam int DEN_W      = DIV_W + 1;
  localparam int NUM_W      = SUM_W + 1;
  localparam int DIV_STEPS  = 6;
  localparam int DIV_STAGES = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int NQ_W       = DIV_STAGES * DIV_STEPS;

  // output stream packing
  localparam int OUT_BITS = PIX_W + 2 * COORD_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_VALID       = 2'd0,
    ST_ALL_INVALID = 2'd1,
    ST_OUTSIDE     = 2'd2
  } status_e;

  // record after the store read
  typedef struct packed {
    logic signed [PIX_W-1:0] value;
    logic                    bad;
    logic                    first;
    logic                    last;
    logic                    win;
    logic                    frame_end;
    logic [FRAME_W-1:0]      frames;
    logic [ROW_W-1:0]        row;
    logic [ROW_W-1:0]        col;
  } s1_t;

  // record after accumulation
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [DIV_W-1:0]        div;
    status_e                 status;
    logic                    frame_end;
    logic [ROW_W-1:0]        row;
    logic [ROW_W-1:0]        col;
  } s2_t;

  // record in the divider stages
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [NQ_W-1:0]  nq;
    logic [DEN_W-1:0] den;
    logic             neg;
    status_e          status;
    logic             frame_end;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
  } pipe_t;

  // one divider stage: DIV_STEPS restoring steps, quotient shifts into nq
  function automatic pipe_t div_step(pipe_t p_in);
    pipe_t          p;
    logic [DEN_W:0] t;
    p = p_in;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {p.rem, p.nq[NQ_W-1]};
      if (t >= {1'b0, p.den}) begin
        p.rem = DEN_W'(t - {1'b0, p.den});
        p.nq  = {p.nq[NQ_W-2:0], 1'b1};
      end else begin
        p.rem = t[DEN_W-1:0];
        p.nq  = {p.nq[NQ_W-2:0], 1'b0};
      end
    end
    return p;
  endfunction

endpackage

// File: rtl/core/frame_average_invalid_mask_top.sv
// frame_average_invalid_mask_top: per-pixel averaging over groups of frames
// with invalid mask, window and fill; holds the sum/count store and divider
// depends on fai_pkg
//
//   channel   dir  handshake                  payload
//   s_axis    in   tvalid/tready              tdata pixel_value, tuser pixel_invalid
//   m_axis    out  tvalid/tready              tdata avg/row/col, tuser status, tlast
//   apb       in   psel/penable/pwrite/pready paddr, pwdata, prdata
//
// one pixel per cycle sustained while the output side accepts; a result
// reaches the output register through store read, accumulate, setup and seven
// divider stages of six steps each. the per-pixel store is a 262144 x 48 memory with
// one read and one write port; it needs no clearing since the first frame of
// each group overwrites. reset clears counters, registers and valid bits.
// a stall only holds stages that are occupied; empty stages keep filling.

module frame_average_invalid_mask_top
  import fai_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [PIX_W-1:0]    s_axis_tdata,   // [31:0] pixel_value
  input  logic [0:0]          s_axis_tuser,   // [0] pixel_invalid
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OUT_W-1:0]    m_axis_tdata,   // [31:0] avg_value, [40:32] out_row,
                                              // [49:41] out_col, rest zero
  output logic [1:0]          m_axis_tuser,   // [1:0] pixel_status
  output logic                m_axis_tlast,   // last_of_frame
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  // configuration registers
  logic [FRAMES_REG_W-1:0] frames_q;
  logic [WSTART_W-1:0]     win_start_q;
  logic [WEND_W-1:0]       win_end_q;
  logic                    cfg_we;
  logic [REG_IDX_W-1:0]    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q    <= FRAMES_REG_W'(1);
      win_start_q <= '0;
      win_end_q   <= WEND_W'(512);
    end else if (cfg_we) begin
      case (reg_idx)
        REG_FRAMES:    frames_q    <= pwdata[FRAMES_REG_W-1:0];
        REG_WIN_START: win_start_q <= pwdata[WSTART_W-1:0];
        REG_WIN_END:   win_end_q   <= pwdata[WEND_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_FRAMES:    prdata = PDATA_W'(frames_q);
      REG_WIN_START: prdata = PDATA_W'(win_start_q);
      REG_WIN_END:   prdata = PDATA_W'(win_end_q);
      default:       prdata = '0;
    endcase
  end

  // stall chain: a stage is free when empty or when it moves on
  logic                  out_v_q;
  logic                  out_take;
  logic                  v1_q;
  logic                  v2_q;
  logic [DIV_STAGES:0]   pv_q;
  logic [DIV_STAGES:0]   pfree;
  logic                  free1;
  logic                  free2;
  logic                  s_accept;

  assign out_take             = !out_v_q || m_axis_tready;
  assign pfree[DIV_STAGES]    = !pv_q[DIV_STAGES] || out_take;
  genvar gf;
  generate
    for (gf = 0; gf < DIV_STAGES; gf++) begin : g_free
      assign pfree[gf] = !pv_q[gf] || pfree[gf+1];
    end
  endgenerate
  assign free2         = !v2_q || pfree[0];
  assign free1         = !v1_q || free2;
  assign s_axis_tready = free1;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // raster position and frame count within group
  logic [ROW_W-1:0]    row_q;
  logic [ROW_W-1:0]    col_q;
  logic [FRAME_W-1:0]  fig_q;
  logic [FRAMEP_W-1:0] n_eff;
  logic [FRAMEP_W-1:0] frames_p;
  logic                last_in;
  logic                win_in;
  logic                row_end;
  logic                col_end;

  always_comb begin
    if (frames_q == '0) begin
      n_eff = FRAMEP_W'(1);
    end else if (32'(frames_q) > MAX_FRAMES) begin
      n_eff = FRAMEP_W'(MAX_FRAMES);
    end else begin
      n_eff = FRAMEP_W'(frames_q);
    end
  end

  assign frames_p = FRAMEP_W'(fig_q) + FRAMEP_W'(1);
  assign last_in  = frames_p >= n_eff;
  assign row_end  = row_q == ROW_W'(IMAGE_SIZE - 1);
  assign col_end  = col_q == ROW_W'(IMAGE_SIZE - 1);
  assign win_in   = (CMP_W'(row_q) >= CMP_W'(win_start_q)) &&
                    (CMP_W'(row_q) <  CMP_W'(win_end_q)) &&
                    (CMP_W'(col_q) >= CMP_W'(win_start_q)) &&
                    (CMP_W'(col_q) <  CMP_W'(win_end_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      fig_q <= '0;
    end else if (s_accept) begin
      if (col_end) begin
        col_q <= '0;
        if (row_end) begin
          row_q <= '0;
          fig_q <= last_in ? '0 : FRAME_W'(frames_p);
        end else begin
          row_q <= row_q + ROW_W'(1);
        end
      end else begin
        col_q <= col_q + ROW_W'(1);
      end
    end
  end

  // stage 1: store read and item record
  logic [MEM_W-1:0] acc_mem_q [DEPTH];
  logic [MEM_W-1:0] mem_rd_q;
  logic [MEM_W-1:0] mem_wr;
  logic             mem_we;
  s1_t              s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (free1) begin
      v1_q <= s_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_q.value     <= s_axis_tdata;
      s1_q.bad       <= s_axis_tuser[0];
      s1_q.first     <= fig_q == '0;
      s1_q.last      <= last_in;
      s1_q.win       <= win_in;
      s1_q.frame_end <= row_end && col_end;
      s1_q.frames    <= FRAME_W'(frames_p);
      s1_q.row       <= row_q;
      s1_q.col       <= col_q;
    end
  end

  // per-pixel store, one read and one write port
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      mem_rd_q <= acc_mem_q[{row_q, col_q}];
    end
    if (mem_we) begin
      acc_mem_q[{s1_q.row, s1_q.col}] <= mem_wr;
    end
  end

  // stage 2: accumulate, write back, pick status and divisor
  s2_t s2_d;
  s2_t s2_q;

  always_comb begin
    logic signed [SUM_W-1:0] old_sum;
    logic signed [SUM_W-1:0] new_sum;
    logic [CNT_W-1:0]        old_k;
    logic [CNT_W-1:0]        new_k;
    old_sum = s1_q.first ? '0 : mem_rd_q[SUM_W-1:0];
    old_k   = s1_q.first ? '0 : mem_rd_q[MEM_W-1:SUM_W];
    new_sum = old_sum;
    new_k   = old_k;
    if (s1_q.bad) begin
      if (old_k != '1) begin
        new_k = old_k + CNT_W'(1);
      end
    end else begin
      new_sum = old_sum + {{(SUM_W-PIX_W){s1_q.value[PIX_W-1]}}, s1_q.value};
    end
    mem_wr = {new_k, new_sum};

    s2_d.sum       = new_sum;
    s2_d.frame_end = s1_q.frame_end;
    s2_d.row       = s1_q.row;
    s2_d.col       = s1_q.col;
    s2_d.div       = DIV_W'(1);
    if (!s1_q.win) begin
      s2_d.status = ST_OUTSIDE;
    end else if (FK_W'(new_k) >= FK_W'(s1_q.frames)) begin
      s2_d.status = ST_ALL_INVALID;
    end else begin
      s2_d.status = ST_VALID;
      s2_d.div    = DIV_W'(FK_W'(s1_q.frames) - FK_W'(new_k));
    end
  end

  assign mem_we = v1_q && free2 && s1_q.win;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (free2) begin
      v2_q <= v1_q && s1_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free2 && v1_q) begin
      s2_q <= s2_d;
    end
  end

  // stage 3: magnitude and divider operands
  pipe_t pipe_q [DIV_STAGES+1];
  pipe_t p0_d;

  always_comb begin
    logic [SUM_W-1:0] mag;
    logic [NUM_W-1:0] num;
    p0_d.neg       = s2_q.sum[SUM_W-1];
    mag            = p0_d.neg ? SUM_W'(-s2_q.sum) : SUM_W'(s2_q.sum);
    num            = {mag, 1'b0} + NUM_W'(s2_q.div);
    p0_d.rem       = '0;
    p0_d.nq        = NQ_W'(num);
    p0_d.den       = {s2_q.div, 1'b0};
    p0_d.status    = s2_q.status;
    p0_d.frame_end = s2_q.frame_end;
    p0_d.row       = s2_q.row;
    p0_d.col       = s2_q.col;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q[0] <= 1'b0;
    end else if (pfree[0]) begin
      pv_q[0] <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pfree[0] && v2_q) begin
      pipe_q[0] <= p0_d;
    end
  end

  // divider stages
  genvar gd;
  generate
    for (gd = 1; gd <= DIV_STAGES; gd++) begin : g_div
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          pv_q[gd] <= 1'b0;
        end else if (pfree[gd]) begin
          pv_q[gd] <= pv_q[gd-1];
        end
      end

      always_ff @(posedge clk_i) begin
        if (pfree[gd] && pv_q[gd-1]) begin
          pipe_q[gd] <= div_step(pipe_q[gd-1]);
        end
      end
    end
  endgenerate

  // sign, clamp and fill, then output register
  logic [PIX_W-1:0]   avg_d;
  logic [PIX_W-1:0]   avg_q;
  status_e            status_q;
  logic [COORD_W-1:0] out_row_q;
  logic [COORD_W-1:0] out_col_q;
  logic               out_last_q;

  always_comb begin
    logic [NQ_W-1:0] q;
    logic [NQ_W-1:0] q_neg;
    q     = pipe_q[DIV_STAGES].nq;
    q_neg = -q;
    case (pipe_q[DIV_STAGES].status)
      ST_VALID: begin
        if (pipe_q[DIV_STAGES].neg) begin
          avg_d = (q > NQ_W'(PIX_MIN)) ? PIX_MIN : q_neg[PIX_W-1:0];
        end else begin
          avg_d = (q > NQ_W'(PIX_MAX)) ? PIX_MAX : q[PIX_W-1:0];
        end
      end
      ST_ALL_INVALID: avg_d = '0;
      ST_OUTSIDE:     avg_d = FILL_Q16;
      default:        avg_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_take) begin
      out_v_q <= pv_q[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take && pv_q[DIV_STAGES]) begin
      avg_q      <= avg_d;
      status_q   <= pipe_q[DIV_STAGES].status;
      out_row_q  <= COORD_W'(pipe_q[DIV_STAGES].row);
      out_col_q  <= COORD_W'(pipe_q[DIV_STAGES].col);
      out_last_q <= pipe_q[DIV_STAGES].frame_end;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = OUT_W'({out_col_q, out_row_q, avg_q});
  assign m_axis_tuser  = status_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  // an empty output register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  // pixels outside the window carry the fill value
  a_fill_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_OUTSIDE) |-> avg_q == FILL_Q16)
    else $error("outside-window result without fill value");

  // an all-invalid pixel reports zero
  a_zero_all_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_ALL_INVALID) |-> avg_q == '0)
    else $error("all-invalid result with nonzero value");

  // the last pixel of a frame wraps the raster position
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && row_end && col_end |=> (row_q == '0) && (col_q == '0))
    else $error("raster position did not wrap at frame end");

  // a new result only comes out of the last divider stage
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(pv_q[DIV_STAGES]))
    else $error("result appeared without a divider item");
`endif

endmodule
